// ----- rtl/core/tswc_pkg.sv -----
// shared constants and types of the threshold spike window capture unit
package tswc_pkg;

  localparam int unsigned Window     = 32;
  localparam int unsigned PreTrigger = 8;
  localparam int unsigned Channels   = 4;
  localparam int unsigned Batch      = 16;

  localparam int unsigned DelayLen = PreTrigger * Channels;
  localparam int unsigned OffW     = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned ChanW    = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned FillW    = $clog2(Batch + 1);

  localparam int unsigned SampleW = 16;
  localparam int unsigned FrameW  = 24;
  localparam int unsigned TotalW  = 20;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  localparam logic [SampleW-1:0] ThresholdRst    = 16'd1000;
  localparam logic [FrameW-1:0]  RecordLengthRst = 24'hFFFFFF;
  localparam logic [TotalW-1:0]  MaxSpikesRst    = 20'd20000;
  localparam logic [FrameW-1:0]  FrameMax        = 24'hFFFFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold    = 2'd0,
    CfgRecordLength = 2'd1,
    CfgMaxSpikes    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TotalW-1:0]  number;
    logic [3:0]         chan;
    logic [7:0]         position;
    logic [SampleW-1:0] value;
    logic               last;
    logic               batch;
  } res_t;

endpackage

// ----- rtl/core/threshold_spike_window_capture_unit.sv -----
// top level of the threshold spike window capture unit
//
// Takes one converter sample per cycle in time-major order and, once channel 0
// reaches the threshold while no window is open and one fits in the record,
// emits a window of Window frames of every channel, starting PreTrigger frames
// earlier from a sample delay line (or at the trigger frame early in a record).
// Each sample is decided combinationally from the input port into the result
// register, or into the skid entry behind it while an untaken result waits; the
// single skid entry keeps the input ready while one finished result waits, so the
// sustained rate is one sample per cycle while results are taken, and ready
// drops only when both the result register and the skid entry are full. Samples
// whose channel lies beyond the channel count are taken and dropped without effect.
module threshold_spike_window_capture_unit
  import tswc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,  // sample
  input  logic [4:0]          s_axis_tuser,  // chan, record_start
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,  // spike_number, position, value, zero pad
  output logic [4:0]          m_axis_tuser,  // out_chan, batch_done
  output logic                m_axis_tlast   // window_last
);

  // configuration
  logic signed [SampleW-1:0] threshold_q;
  logic [FrameW-1:0]         record_length_q;
  logic [TotalW-1:0]         max_spikes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q     <= ThresholdRst;
      record_length_q <= RecordLengthRst;
      max_spikes_q    <= MaxSpikesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgThreshold:    threshold_q     <= cfg_data_i[SampleW-1:0];
        CfgRecordLength: record_length_q <= cfg_data_i[FrameW-1:0];
        CfgMaxSpikes:    max_spikes_q    <= cfg_data_i[TotalW-1:0];
        default: ;
      endcase
    end
  end

  // state
  logic [FrameW-1:0] frame_q, frame_d;
  logic              open_q, open_d;
  logic              cap_q, cap_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [ChanW-1:0]  emit_q, emit_d;
  logic              nodly_q, nodly_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              halted_q, halted_d;
  logic [TotalW-1:0] lnum_q, lnum_d;
  logic              lbatch_q, lbatch_d;

  logic               out_valid_q, skid_valid_q;
  res_t               out_q, skid_q, res;
  logic               res_valid;

  logic signed [SampleW-1:0] smp;
  logic [3:0]                chan_in;
  logic                      rstart;
  logic                      xfer, take;
  logic [SampleW-1:0]        delayed;
  logic                      trig, fill_full;
  logic [FillW-1:0]          fill_inc;

  assign smp     = s_axis_tdata;
  assign chan_in = s_axis_tuser[3:0];
  assign rstart  = s_axis_tuser[4];

  assign s_axis_tready = !skid_valid_q;
  assign xfer = s_axis_tvalid && s_axis_tready && (32'(chan_in) < Channels);
  assign take = out_valid_q && m_axis_tready;

  // pre-trigger delay line
  if (DelayLen > 0) begin : g_delay
    logic [SampleW-1:0] hist_q [DelayLen];
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < DelayLen; i++) hist_q[i] <= '0;
      end else if (xfer) begin
        hist_q[0] <= smp;
        for (int i = 1; i < DelayLen; i++) hist_q[i] <= hist_q[i-1];
      end
    end
    assign delayed = hist_q[DelayLen-1];
  end else begin : g_nodelay
    assign delayed = smp;
  end

  always_comb begin
    frame_d  = frame_q;
    open_d   = open_q;
    cap_d    = cap_q;
    off_d    = off_q;
    emit_d   = emit_q;
    nodly_d  = nodly_q;
    total_d  = total_q;
    fill_d   = fill_q;
    halted_d = halted_q;
    lnum_d   = lnum_q;
    lbatch_d = lbatch_q;
    trig     = 1'b0;
    fill_inc = '0;
    fill_full = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (xfer) begin
      if (rstart) begin
        frame_d  = '0;
        open_d   = 1'b1;
        total_d  = '0;
        fill_d   = '0;
        halted_d = 1'b0;
        cap_d    = 1'b0;
        off_d    = '0;
        emit_d   = '0;
        lbatch_d = 1'b0;
      end else if (chan_in == 4'd0) begin
        if (!open_q) begin
          frame_d = '0;
        end else if (frame_q < FrameMax) begin
          frame_d = frame_q + 1'b1;
        end
        open_d = 1'b1;
      end

      trig = (chan_in == 4'd0) && !cap_d && !halted_d &&
             (({1'b0, frame_d} + (FrameW+1)'(Window)) < {1'b0, record_length_q}) &&
             (smp >= threshold_q);

      if (trig) begin
        cap_d     = 1'b1;
        nodly_d   = (32'(frame_d) < PreTrigger);
        off_d     = '0;
        emit_d    = '0;
        lnum_d    = total_d;
        total_d   = total_d + 1'b1;
        fill_inc  = fill_d + 1'b1;
        fill_full = (32'(fill_inc) >= Batch);
        lbatch_d  = fill_full;
        fill_d    = fill_full ? '0 : fill_inc;
        if (fill_full && (total_d == max_spikes_q)) begin
          halted_d = 1'b1;
        end
      end

      if (cap_d) begin
        res_valid    = 1'b1;
        res.number   = lnum_d;
        res.chan     = 4'(emit_d);
        res.position = 8'(off_d);
        res.value    = nodly_d ? smp : delayed;
        res.last     = (32'(off_d) >= Window - 1) && (32'(emit_d) >= Channels - 1);
        res.batch    = lbatch_d;
        if (res.last) begin
          cap_d  = 1'b0;
          off_d  = '0;
          emit_d = '0;
        end else if (32'(emit_d) >= Channels - 1) begin
          emit_d = '0;
          off_d  = off_d + 1'b1;
        end else begin
          emit_d = emit_d + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q  <= '0;
      open_q   <= 1'b0;
      cap_q    <= 1'b0;
      off_q    <= '0;
      emit_q   <= '0;
      nodly_q  <= 1'b0;
      total_q  <= '0;
      fill_q   <= '0;
      halted_q <= 1'b0;
      lnum_q   <= '0;
      lbatch_q <= 1'b0;
    end else begin
      frame_q  <= frame_d;
      open_q   <= open_d;
      cap_q    <= cap_d;
      off_q    <= off_d;
      emit_q   <= emit_d;
      nodly_q  <= nodly_d;
      total_q  <= total_d;
      fill_q   <= fill_d;
      halted_q <= halted_d;
      lnum_q   <= lnum_d;
      lbatch_q <= lbatch_d;
    end
  end

  // result register with one skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q.value, out_q.position, out_q.number};
  assign m_axis_tuser  = {out_q.batch, out_q.chan};
  assign m_axis_tlast  = out_q.last;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while result register empty");

  a_idle_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cap_q |-> (off_q == '0 && emit_q == '0))
    else $error("window counters not cleared outside a capture");

  a_halt_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (fill_q == '0))
    else $error("batch fill not empty while halted");

  a_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.last) |-> (32'(out_q.chan) == Channels - 1))
    else $error("window ends on a channel other than the last");

endmodule
